// ===== hw/rtl/spq_pkg.sv =====
// Shared types, codes and defaults for the sorted minimum priority queue.
package spq_pkg;

    // Default sizing
    localparam int CAPACITY_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Fixed field widths of the channels
    localparam int FIELD_BITS = 32;
    localparam int KEY_BITS   = 32;
    localparam int OCC_BITS   = 5;

    // Operation codes
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } spq_op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } spq_status_t;

    // Request beat
    typedef struct packed {
        spq_op_t                      opcode;
        logic [FIELD_BITS-1:0]        payload;
        logic signed [KEY_BITS-1:0]   sort_key;
    } spq_req_t;

    // Response beat
    typedef struct packed {
        logic [FIELD_BITS-1:0]        out_payload;
        logic signed [KEY_BITS-1:0]   out_key;
        spq_status_t                  status;
        logic [OCC_BITS-1:0]          occupancy;
    } spq_rsp_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic                         push;
        logic                         pop;
        logic signed [KEY_BITS-1:0]   new_key;
        logic [FIELD_BITS-1:0]        new_payload;
    } spq_cell_ctrl_t;

endpackage

// ===== hw/rtl/spq_if.sv =====
// Valid/ready stream interface carrying one beat of a given type.
interface spq_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sorted_min_priority_queue.sv =====
// Top level of the sorted minimum priority queue built as a chain of cells.
//
// Usage: request beats carry an opcode (push or pop), a payload and a signed
// Q16.16 sort key. Every request gives exactly one response beat with the
// popped payload and key (zero unless a pop succeeded), a status code and the
// occupancy after the operation.
// A push lands behind every held entry of equal or smaller key, so ties leave
// in arrival order; a push to a full queue is dropped and flagged, a pop of an
// empty queue is flagged.
// Latency: the response is valid the cycle after the request beat is taken.
// Throughput: one request per cycle. Every cell compares its key with the
// broadcast key and shifts as the beat is taken, so the chain never holds up the
// next beat; the rate is set by the single output register alone.
// Stall: while a response waits in the output register and the receiver holds
// ready low, request ready is low; it returns as soon as the response is taken.
// Reset: the queue is empty and no response is pending; slot contents are
// left as they are and are never read until written.
module sorted_min_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    spq_stream_if.sink   request,
    spq_stream_if.source response
);

    localparam int STORE_BITS = (PAYLOAD_BITS < FIELD_BITS) ? PAYLOAD_BITS : FIELD_BITS;
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);

    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    spq_rsp_t            rsp_reg;
    spq_rsp_t            rsp_next;

    logic                accept;
    logic                is_push;
    logic                full;
    logic                empty;
    spq_cell_ctrl_t      ctrl;

    logic signed [KEY_BITS-1:0] cell_key     [CAPACITY];
    logic [STORE_BITS-1:0]      cell_payload [CAPACITY];
    logic [CAPACITY-1:0]        cell_greater;

    // Handshake: take a beat whenever the output register is free or draining
    assign request.ready = !rsp_valid_reg || response.ready;
    assign accept        = request.valid && request.ready;

    assign is_push = (request.data.opcode == OP_PUSH);
    assign full    = (count_reg == CNT_BITS'(CAPACITY));
    assign empty   = (count_reg == '0);

    // Broadcast to the chain
    always_comb
    begin
        ctrl.push        = accept && is_push && !full;
        ctrl.pop         = accept && !is_push && !empty;
        ctrl.new_key     = request.data.sort_key;
        ctrl.new_payload = request.data.payload;
    end

    // Chain of slots, slot 0 holds the smallest key
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                       left_greater;
        logic signed [KEY_BITS-1:0] left_key;
        logic [STORE_BITS-1:0]      left_payload;
        logic signed [KEY_BITS-1:0] right_key;
        logic [STORE_BITS-1:0]      right_payload;

        if (i == 0)
        begin : g_head
            assign left_greater = 1'b0;
            assign left_key     = '0;
            assign left_payload = '0;
        end
        else
        begin : g_body
            assign left_greater = cell_greater[i-1];
            assign left_key     = cell_key[i-1];
            assign left_payload = cell_payload[i-1];
        end

        // Last slot refills from itself; it is beyond the count after a pop
        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_key     = cell_key[i];
            assign right_payload = cell_payload[i];
        end
        else
        begin : g_next
            assign right_key     = cell_key[i+1];
            assign right_payload = cell_payload[i+1];
        end

        spq_cell #(
            .STORE_BITS (STORE_BITS)
        ) u_cell (
            .clk           (clk),
            .ctrl          (ctrl),
            .occupied      (count_reg > CNT_BITS'(i)),
            .slot_hit      (count_reg == CNT_BITS'(i)),
            .left_greater  (left_greater),
            .left_key      (left_key),
            .left_payload  (left_payload),
            .right_key     (right_key),
            .right_payload (right_payload),
            .greater       (cell_greater[i]),
            .key           (cell_key[i]),
            .payload       (cell_payload[i])
        );
    end

    // Count and response
    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && response.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.out_payload = '0;
            rsp_next.out_key     = '0;
            if (ctrl.push)
            begin
                count_next      = count_reg + 1'b1;
                rsp_next.status = ST_PUSHED;
            end
            else if (ctrl.pop)
            begin
                count_next           = count_reg - 1'b1;
                rsp_next.status      = ST_POPPED;
                rsp_next.out_payload = FIELD_BITS'(cell_payload[0]);
                rsp_next.out_key     = cell_key[0];
            end
            else if (is_push)
            begin
                rsp_next.status = ST_FULL;
            end
            else
            begin
                rsp_next.status = ST_EMPTY;
            end
            rsp_next.occupancy = OCC_BITS'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response beat, payload only
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign response.valid = rsp_valid_reg;
    assign response.data  = rsp_reg;

    // Count never runs past the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(CAPACITY))
        else $error("entry count beyond capacity");

    // A push into a full queue is reported as dropped and leaves the count alone
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_push && full) |=>
            (response.valid && response.data.status == ST_FULL && count_reg == $past(count_reg)))
        else $error("push to full queue not dropped");

    // A successful pop returns the head slot and lowers the count by one
    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_push && !empty) |=>
            (response.data.out_key == $past(cell_key[0])
             && count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not return the head entry");

    // The head slot never holds a larger key than its neighbour
    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg > CNT_BITS'(1)) |-> (cell_key[0] <= cell_key[1]))
        else $error("head slot out of order");

endmodule

// ===== hw/rtl/spq_cell.sv =====
// One slot of the sorted chain: holds a key and payload, shifts right on push, left on pop.
module spq_cell
    import spq_pkg::*;
#(
    parameter int STORE_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                        clk,
    input  spq_cell_ctrl_t              ctrl,
    input  logic                        occupied,
    input  logic                        slot_hit,
    input  logic                        left_greater,
    input  logic signed [KEY_BITS-1:0]  left_key,
    input  logic [STORE_BITS-1:0]       left_payload,
    input  logic signed [KEY_BITS-1:0]  right_key,
    input  logic [STORE_BITS-1:0]       right_payload,
    output logic                        greater,
    output logic signed [KEY_BITS-1:0]  key,
    output logic [STORE_BITS-1:0]       payload
);

    logic signed [KEY_BITS-1:0] key_reg;
    logic signed [KEY_BITS-1:0] key_next;
    logic [STORE_BITS-1:0]      payload_reg;
    logic [STORE_BITS-1:0]      payload_next;

    // Held entry strictly above the new key: it moves aside for the newcomer
    assign greater = occupied && (ctrl.new_key < key_reg);

    // Slot update
    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctrl.push)
        begin
            if (left_greater)
            begin
                key_next     = left_key;
                payload_next = left_payload;
            end
            else if (greater || slot_hit)
            begin
                key_next     = ctrl.new_key;
                payload_next = STORE_BITS'(ctrl.new_payload);
            end
        end
        else if (ctrl.pop)
        begin
            key_next     = right_key;
            payload_next = right_payload;
        end
    end

    // Entry storage, no reset: slots above the count are never read
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;

endmodule
